[hdl/c3v_pkg.sv]
// Shared types and constants of the streaming 3x3 convolution core.
// No dependencies; every other file of the block refers to this package.
package c3v_pkg;

    // Kernel size and geometry.
    localparam int KSIZE     = 3;
    localparam int NUM_TAPS  = KSIZE * KSIZE;
    localparam int DIM_REG_W = 12;
    localparam int DIM_W     = 14;

    // Pixel field on the input channel.
    localparam int PIX_PORT_W = 8;

    // Coefficient register layout: three 16-bit slots per kernel row.
    localparam int COEF_SLOT_W = 16;
    localparam int CFG_W       = 48;

    // Result width.
    localparam int SUM_W = 28;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2 = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [DIM_REG_W-1:0] DIM_RESET  = 12'd2048;
    localparam logic [CFG_W-1:0]     COEF_RESET = 48'h071C_071C_071C;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CFG_W-1:0]        coef_row_t;

    // Position flags that travel with each window.
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } flags_t;

endpackage

[hdl/c3v_if.sv]
// Stream interfaces of the convolution core: pixel input and result output.
// Depends on c3v_pkg for the payload types.
interface c3v_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [c3v_pkg::PIX_PORT_W-1:0]    pixel;
    logic                              frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c3v_result_if;
    logic          valid;
    logic          ready;
    c3v_pkg::sum_t sum;
    logic          row_end;
    logic          frame_end;

    modport source (output valid, output sum, output row_end, output frame_end, input ready);
    modport sink   (input valid, input sum, input row_end, input frame_end, output ready);
endinterface

[hdl/c3v_front.sv]
// Front part: accepts pixels, tracks row and column, keeps the two line stores
// and the window columns, and pushes each complete 3x3 window. Uses c3v_pkg.
module c3v_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int PIX_W      = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    c3v_pixel_if.sink                         pixels,
    input  logic [c3v_pkg::DIM_REG_W-1:0]     row_width,
    input  logic [c3v_pkg::DIM_REG_W-1:0]     row_count,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [c3v_pkg::NUM_TAPS*PIX_W-1:0] push_win,
    output c3v_pkg::flags_t                   push_flags
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Position counters for the next pixel.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage holding the accepted pixel while the line store read completes.
    logic             s1_valid_reg;
    logic             s1_result_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    c3v_pkg::flags_t  s1_flags_reg;

    // Line stores, their read data, and the same-address bypass.
    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] u_rd_reg, m_rd_reg;
    logic             fwd_sel_reg;
    logic [PIX_W-1:0] fwd_u_reg, fwd_m_reg;

    // Two previous columns of the window: [0..2] oldest, [3..5] newer.
    logic [PIX_W-1:0] win_reg [6];

    logic                       accept, drain;
    logic [COL_W-1:0]           col_cur;
    logic [ROW_W-1:0]           row_cur;
    logic [c3v_pkg::DIM_W-1:0]  w_ext, h_ext, last_col_idx, last_row_idx;
    logic                       last_col, last_row, has_result;
    logic [PIX_W-1:0]           pix_in, s1_u, s1_m;

    // Handshake: the stage drains unless a window waits for queue space.
    assign accept       = pixels.valid && pixels.ready;
    assign drain        = s1_valid_reg && (!s1_result_reg || push_ready);
    assign pixels.ready = !s1_valid_reg || drain;
    assign pix_in       = pixels.pixel[PIX_W-1:0];

    // Geometry, clamped into the supported range.
    always_comb
    begin
        w_ext = c3v_pkg::DIM_W'(row_width);
        h_ext = c3v_pkg::DIM_W'(row_count);
        if (w_ext < c3v_pkg::DIM_W'(c3v_pkg::KSIZE))
            w_ext = c3v_pkg::DIM_W'(c3v_pkg::KSIZE);
        else if (w_ext > c3v_pkg::DIM_W'(MAX_WIDTH))
            w_ext = c3v_pkg::DIM_W'(MAX_WIDTH);
        if (h_ext < c3v_pkg::DIM_W'(c3v_pkg::KSIZE))
            h_ext = c3v_pkg::DIM_W'(c3v_pkg::KSIZE);
        else if (h_ext > c3v_pkg::DIM_W'(MAX_HEIGHT))
            h_ext = c3v_pkg::DIM_W'(MAX_HEIGHT);
        last_col_idx = w_ext - c3v_pkg::DIM_W'(1);
        last_row_idx = h_ext - c3v_pkg::DIM_W'(1);
    end

    // Position of the incoming pixel and the counters for the one after it.
    always_comb
    begin
        col_cur    = pixels.frame_start ? '0 : col_reg;
        row_cur    = pixels.frame_start ? '0 : row_reg;
        last_col   = c3v_pkg::DIM_W'(col_cur) >= last_col_idx;
        last_row   = c3v_pkg::DIM_W'(row_cur) >= last_row_idx;
        has_result = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                fwd_sel_reg  <= drain && (col_cur == s1_col_reg);
            end
            else if (drain)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg          <= has_result;
            s1_col_reg             <= col_cur;
            s1_pix_reg             <= pix_in;
            s1_flags_reg.row_end   <= last_col;
            s1_flags_reg.frame_end <= last_col && last_row;
            fwd_u_reg              <= s1_m;
            fwd_m_reg              <= s1_pix_reg;
        end
    end

    // Line stores: written as a pixel leaves the stage, read as one enters.
    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            upper_mem[s1_col_reg]  <= s1_m;
            middle_mem[s1_col_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            u_rd_reg <= upper_mem[col_cur];
            m_rd_reg <= middle_mem[col_cur];
        end
    end

    // A write in the same cycle as the read of that address is forwarded.
    assign s1_u = fwd_sel_reg ? fwd_u_reg : u_rd_reg;
    assign s1_m = fwd_sel_reg ? fwd_m_reg : m_rd_reg;

    // Window shift on every pixel that leaves the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (drain)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1_u;
            win_reg[4] <= s1_m;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // Window out, tap index = kernel row * 3 + kernel column.
    always_comb
    begin
        for (int ky = 0; ky < c3v_pkg::KSIZE; ky++)
        begin
            push_win[(ky*c3v_pkg::KSIZE)*PIX_W +: PIX_W]     = win_reg[ky];
            push_win[(ky*c3v_pkg::KSIZE + 1)*PIX_W +: PIX_W] = win_reg[3 + ky];
        end
        push_win[2*PIX_W +: PIX_W] = s1_u;
        push_win[5*PIX_W +: PIX_W] = s1_m;
        push_win[8*PIX_W +: PIX_W] = s1_pix_reg;
    end

    assign push_valid = s1_valid_reg && s1_result_reg;
    assign push_flags = s1_flags_reg;

    // A window that cannot be pushed stays in the stage unchanged.
    a_hold_window: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> s1_valid_reg && s1_result_reg && $stable(s1_col_reg))
        else $error("window lost while the queue was full");

    // A frame start always places the pixel in column zero.
    a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pixels.frame_start |=> s1_col_reg == '0)
        else $error("frame start did not restart the column count");

endmodule

[hdl/c3v_queue.sv]
// Short queue between the front and the back of the convolution core.
// Register based, one write and one read per cycle; a write needs a free slot. Uses c3v_pkg.
module c3v_queue #(
    parameter int DATA_W = 74
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PW = c3v_pkg::QUEUE_PTR_W;

    logic [DATA_W-1:0] slot_reg [c3v_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              push, pop;

    assign push_ready = count_reg < (PW+1)'(c3v_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(c3v_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

[hdl/c3v_back.sv]
// Back part: nine products, three row sums and the final sum, each stage
// registered, ending in the output register. Uses c3v_pkg and c3v_result_if.
module c3v_back #(
    parameter int PIX_W     = 8,
    parameter int COEF_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  c3v_pkg::coef_row_t                 coef_row0,
    input  c3v_pkg::coef_row_t                 coef_row1,
    input  c3v_pkg::coef_row_t                 coef_row2,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  logic [c3v_pkg::NUM_TAPS*PIX_W-1:0] pop_win,
    input  c3v_pkg::flags_t                    pop_flags,
    c3v_result_if.source                       results
);
    localparam int PROD_W = PIX_W + 1 + COEF_BITS;

    logic                     en;
    logic                     p_valid_reg, r_valid_reg, out_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [c3v_pkg::NUM_TAPS];
    logic signed [PROD_W-1:0] prod [c3v_pkg::NUM_TAPS];
    c3v_pkg::sum_t            rsum_reg [c3v_pkg::KSIZE];
    c3v_pkg::sum_t            sum_reg;
    c3v_pkg::flags_t          p_flags_reg, r_flags_reg, out_flags_reg;
    c3v_pkg::coef_row_t       coef_rows [c3v_pkg::KSIZE];
    logic signed [COEF_BITS-1:0] coef [c3v_pkg::NUM_TAPS];
    logic signed [PIX_W:0]       pix [c3v_pkg::NUM_TAPS];

    // The whole pipeline moves when the output register can take a result.
    assign en        = !out_valid_reg || results.ready;
    assign pop_ready = en;

    assign coef_rows[0] = coef_row0;
    assign coef_rows[1] = coef_row1;
    assign coef_rows[2] = coef_row2;

    // Nine coefficient-times-pixel products.
    always_comb
    begin
        for (int ky = 0; ky < c3v_pkg::KSIZE; ky++)
        begin
            for (int kx = 0; kx < c3v_pkg::KSIZE; kx++)
            begin
                coef[ky*c3v_pkg::KSIZE + kx] =
                    coef_rows[ky][kx*c3v_pkg::COEF_SLOT_W +: COEF_BITS];
                pix[ky*c3v_pkg::KSIZE + kx] =
                    {1'b0, pop_win[(ky*c3v_pkg::KSIZE + kx)*PIX_W +: PIX_W]};
            end
        end
        for (int i = 0; i < c3v_pkg::NUM_TAPS; i++)
            prod[i] = PROD_W'(pix[i]) * PROD_W'(coef[i]);
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg   <= pop_valid;
            r_valid_reg   <= p_valid_reg;
            out_valid_reg <= r_valid_reg;
        end
    end

    // Product, row sum and total sum registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < c3v_pkg::NUM_TAPS; i++)
                prod_reg[i] <= prod[i];
            p_flags_reg <= pop_flags;
            for (int ky = 0; ky < c3v_pkg::KSIZE; ky++)
                rsum_reg[ky] <= c3v_pkg::sum_t'(prod_reg[ky*c3v_pkg::KSIZE])
                              + c3v_pkg::sum_t'(prod_reg[ky*c3v_pkg::KSIZE + 1])
                              + c3v_pkg::sum_t'(prod_reg[ky*c3v_pkg::KSIZE + 2]);
            r_flags_reg   <= p_flags_reg;
            sum_reg       <= rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
            out_flags_reg <= r_flags_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.sum       = sum_reg;
    assign results.row_end   = out_flags_reg.row_end;
    assign results.frame_end = out_flags_reg.frame_end;

    // A window taken from the queue is in the product stage in the next cycle.
    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> p_valid_reg)
        else $error("window taken from the queue was dropped");

    // A frame end is always also a row end.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_end |-> results.row_end)
        else $error("frame end without row end");

endmodule

[hdl/conv2d_3x3_valid_stream_core.sv]
// Top level of the streaming 3x3 valid-region convolution core.
// Depends on c3v_pkg, c3v_if, c3v_front, c3v_queue and c3v_back.

// The core takes one pixel per transaction, row by row, and sustains one
// pixel per clock cycle: each line store can be read and written in the same
// cycle, and the nine products and their sums are spread over three
// registered stages. A result passes the front stage, the queue and the three
// back stages, one result for every pixel at row two or more and column two
// or more. A short queue between the pixel front and the arithmetic back lets
// the input keep flowing while the output is stalled, until the queue fills.
// Line stores start undefined and need no clearing; configuration registers
// should be written only while the core is idle.
module conv2d_3x3_valid_stream_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [c3v_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [c3v_pkg::CFG_W-1:0]       wr_data,
    c3v_pixel_if.sink                       pixels,
    c3v_result_if.source                    results
);
    localparam int PIX_W  = (PIXEL_BITS < c3v_pkg::PIX_PORT_W) ? PIXEL_BITS
                                                               : c3v_pkg::PIX_PORT_W;
    localparam int WIN_W  = c3v_pkg::NUM_TAPS * PIX_W;
    localparam int DATA_W = WIN_W + $bits(c3v_pkg::flags_t);

    logic [c3v_pkg::DIM_REG_W-1:0] row_width_reg, row_count_reg;
    c3v_pkg::coef_row_t            coef_row0_reg, coef_row1_reg, coef_row2_reg;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    logic [WIN_W-1:0]  push_win;
    c3v_pkg::flags_t   push_flags, pop_flags;
    logic [DATA_W-1:0] pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= c3v_pkg::DIM_RESET;
            row_count_reg <= c3v_pkg::DIM_RESET;
            coef_row0_reg <= c3v_pkg::COEF_RESET;
            coef_row1_reg <= c3v_pkg::COEF_RESET;
            coef_row2_reg <= c3v_pkg::COEF_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                c3v_pkg::REG_ROW_WIDTH: row_width_reg <= wr_data[c3v_pkg::DIM_REG_W-1:0];
                c3v_pkg::REG_ROW_COUNT: row_count_reg <= wr_data[c3v_pkg::DIM_REG_W-1:0];
                c3v_pkg::REG_COEF_ROW0: coef_row0_reg <= wr_data;
                c3v_pkg::REG_COEF_ROW1: coef_row1_reg <= wr_data;
                c3v_pkg::REG_COEF_ROW2: coef_row2_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Front: position tracking, line stores and window.
    c3v_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIX_W      (PIX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .row_width  (row_width_reg),
        .row_count  (row_count_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_win   (push_win),
        .push_flags (push_flags)
    );

    // Queue of complete windows.
    c3v_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_flags, push_win}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_flags = pop_data[DATA_W-1:WIN_W];

    // Back: weighted sum and output register.
    c3v_back #(
        .PIX_W     (PIX_W),
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_row0 (coef_row0_reg),
        .coef_row1 (coef_row1_reg),
        .coef_row2 (coef_row2_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_win   (pop_data[WIN_W-1:0]),
        .pop_flags (pop_flags),
        .results   (results)
    );

endmodule

[tb/conv2d_3x3_valid_stream_core_tb.sv]
`timescale 1ns / 100ps
// Testbench of the streaming 3x3 valid-region convolution core: a window-sum tracker
// predicts every result from the accepted pixels, and plain tasks drive the pixel stream.
// Depends on c3v_pkg, the c3v_if interfaces and conv2d_3x3_valid_stream_core.
module conv2d_3x3_valid_stream_core_tb;

    localparam int LINE_LEN     = 2048;
    localparam int ROWS_MAX     = 2048;
    localparam int PIX_BITS     = 8;
    localparam int COEF_BITS    = 16;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_OFF     = 150;
    localparam int DRAIN_WAIT   = 16;
    localparam int TOTAL_ITEMS  = 750;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        c3v_pkg::sum_t sum;
        logic          row_end;
        logic          frame_end;
    } window_result_t;

    // Tracks line stores, window columns and counts of the core and queues the
    // window sums that the accepted pixels complete.
    class window_sum_checker;
        int unsigned        width_reg;
        int unsigned        height_reg;
        c3v_pkg::coef_row_t coef[c3v_pkg::KSIZE];
        logic [7:0]         upper_line[LINE_LEN];
        logic [7:0]         middle_line[LINE_LEN];
        logic [7:0]         window[2*c3v_pkg::KSIZE];
        logic [10:0]        col_idx;
        logic [10:0]        row_idx;
        window_result_t     sums_due[$];
        int unsigned        errors;

        function new();
            width_reg  = c3v_pkg::DIM_RESET;
            height_reg = c3v_pkg::DIM_RESET;
            foreach (coef[i])
                coef[i] = c3v_pkg::COEF_RESET;
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            col_idx = '0;
            row_idx = '0;
            errors  = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < c3v_pkg::KSIZE)
                return c3v_pkg::KSIZE;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned active_width();
            return clamp_dim(width_reg, LINE_LEN);
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        function void set_register(logic [c3v_pkg::CFG_IDX_W-1:0] idx,
                                   logic [c3v_pkg::CFG_W-1:0] data);
            case (idx)
                c3v_pkg::REG_ROW_WIDTH: width_reg  = data[c3v_pkg::DIM_REG_W-1:0];
                c3v_pkg::REG_ROW_COUNT: height_reg = data[c3v_pkg::DIM_REG_W-1:0];
                c3v_pkg::REG_COEF_ROW0: coef[0]    = data;
                c3v_pkg::REG_COEF_ROW1: coef[1]    = data;
                c3v_pkg::REG_COEF_ROW2: coef[2]    = data;
                default: ;
            endcase
        endfunction

        // One accepted pixel: work out its window sum, if any, and advance the counts.
        function void take_pixel(logic [7:0] pix, logic frame_start);
            int unsigned        w;
            int unsigned        h;
            logic [7:0]         up;
            logic [7:0]         mid;
            logic [7:0]         tap;
            logic signed [15:0] k;
            longint             acc;
            bit                 last_col;
            bit                 last_row;
            window_result_t     r;
            w = active_width();
            h = clamp_dim(height_reg, ROWS_MAX);
            if (frame_start)
            begin
                col_idx = '0;
                row_idx = '0;
            end
            up       = upper_line[col_idx];
            mid      = middle_line[col_idx];
            last_col = (col_idx >= w - 1);
            last_row = (row_idx >= h - 1);

            // Column 0 of the kernel is the oldest window column, column 2 the current one.
            if (row_idx >= 2 && col_idx >= 2)
            begin
                acc = 0;
                for (int ky = 0; ky < c3v_pkg::KSIZE; ky++)
                    for (int kx = 0; kx < c3v_pkg::KSIZE; kx++)
                    begin
                        tap = (kx == 0) ? window[ky] :
                              (kx == 1) ? window[c3v_pkg::KSIZE + ky] :
                              (ky == 0) ? up : (ky == 1) ? mid : pix;
                        k = coef[ky][c3v_pkg::COEF_SLOT_W*kx +: c3v_pkg::COEF_SLOT_W];
                        acc += k * int'(tap);
                    end
                r.sum       = c3v_pkg::sum_t'(acc);
                r.row_end   = last_col;
                r.frame_end = last_col && last_row;
                sums_due.push_back(r);
            end

            upper_line[col_idx]  = mid;
            middle_line[col_idx] = pix;
            for (int i = 0; i < c3v_pkg::KSIZE; i++)
            begin
                window[i]                  = window[c3v_pkg::KSIZE + i];
                window[c3v_pkg::KSIZE + i] = (i == 0) ? up : (i == 1) ? mid : pix;
            end

            if (last_col)
            begin
                col_idx = '0;
                row_idx = last_row ? '0 : row_idx + 1'b1;
            end
            else
                col_idx = col_idx + 1'b1;
        endfunction

        function void note_error(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        // One accepted result against the oldest waiting window sum.
        function void check_result(c3v_pkg::sum_t sum, logic row_end, logic frame_end);
            window_result_t want;
            if (sums_due.size() == 0)
            begin
                note_error($sformatf("unexpected result: sum %0d row_end %0b frame_end %0b",
                                     sum, row_end, frame_end));
                return;
            end
            want = sums_due.pop_front();
            if (sum !== want.sum)
                note_error($sformatf("sum: expected %0d, actual %0d", want.sum, sum));
            if (row_end !== want.row_end)
                note_error($sformatf("row_end: expected %0b, actual %0b",
                                     want.row_end, row_end));
            if (frame_end !== want.frame_end)
                note_error($sformatf("frame_end: expected %0b, actual %0b",
                                     want.frame_end, frame_end));
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          wr_en;
    logic [c3v_pkg::CFG_IDX_W-1:0] wr_index;
    logic [c3v_pkg::CFG_W-1:0]     wr_data;
    bit                            steady;
    bit                            hold_request = 1'b0;
    int unsigned                   cycle_count = 0;

    c3v_pixel_if  pixels_bus ();
    c3v_result_if results_bus ();

    window_sum_checker sums = new();

    conv2d_3x3_valid_stream_core #(
        .MAX_WIDTH  (LINE_LEN),
        .MAX_HEIGHT (ROWS_MAX),
        .PIXEL_BITS (PIX_BITS),
        .COEF_BITS  (COEF_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixels   (pixels_bus),
        .results  (results_bus)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge; a pixel is taken before any result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixels_bus.valid && pixels_bus.ready)
                sums.take_pixel(pixels_bus.pixel, pixels_bus.frame_start);
            if (results_bus.valid && results_bus.ready)
                sums.check_result(results_bus.sum, results_bus.row_end, results_bus.frame_end);
        end
    end

    // Wait before one transaction: mostly none, sometimes a random wait bounded by MAX_GAP.
    function automatic int unsigned draw_gap();
        if (steady || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly small frames; values below three clamp upward, and heights can be huge.
    function automatic logic [c3v_pkg::DIM_REG_W-1:0] pick_dim(bit is_width);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return c3v_pkg::DIM_REG_W'($urandom_range(0, 2));
        if (sel <= 5)
            return c3v_pkg::DIM_REG_W'($urandom_range(3, 8));
        if (sel <= 8)
            return is_width ? c3v_pkg::DIM_REG_W'($urandom_range(9, 40)) :
                              c3v_pkg::DIM_REG_W'($urandom_range(9, 30));
        return is_width ? c3v_pkg::DIM_REG_W'($urandom_range(41, 200)) :
                          (($urandom_range(0, 1) == 0) ? 12'hFFF : 12'd2048);
    endfunction

    function automatic c3v_pkg::coef_row_t pick_coef_row();
        c3v_pkg::coef_row_t row;
        for (int i = 0; i < c3v_pkg::KSIZE; i++)
            case ($urandom_range(0, 5))
                0:       row[c3v_pkg::COEF_SLOT_W*i +: c3v_pkg::COEF_SLOT_W] = 16'h8000;
                1:       row[c3v_pkg::COEF_SLOT_W*i +: c3v_pkg::COEF_SLOT_W] = 16'h7FFF;
                2:       row[c3v_pkg::COEF_SLOT_W*i +: c3v_pkg::COEF_SLOT_W] = 16'h0000;
                default: row[c3v_pkg::COEF_SLOT_W*i +: c3v_pkg::COEF_SLOT_W] = 16'($urandom);
            endcase
        return row;
    endfunction

    // Result side: a fresh wait per transaction, plus one long hold once it is requested.
    initial
    begin : result_sink
        int unsigned gap;
        bit          hold_taken;
        results_bus.ready = 1'b0;
        hold_taken        = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_request && !hold_taken)
            begin
                gap += HOLD_OFF;
                hold_taken = 1'b1;
            end
            if (gap > 0)
            begin
                results_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            results_bus.ready <= 1'b1;
            @(posedge clk);
            while (!(results_bus.valid && results_bus.ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            pixels_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixels_bus.valid       <= 1'b1;
        pixels_bus.pixel       <= pix;
        pixels_bus.frame_start <= fs;
        @(posedge clk);
        while (!(pixels_bus.valid && pixels_bus.ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering pixels, wait for every window sum, then let border pixels settle.
    task automatic finish_phase();
        pixels_bus.valid <= 1'b0;
        while (sums.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [c3v_pkg::CFG_IDX_W-1:0] idx,
                             input logic [c3v_pkg::CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        sums.set_register(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [c3v_pkg::DIM_REG_W-1:0] w,
                                input logic [c3v_pkg::DIM_REG_W-1:0] h,
                                input c3v_pkg::coef_row_t c0, input c3v_pkg::coef_row_t c1,
                                input c3v_pkg::coef_row_t c2);
        write_reg(c3v_pkg::REG_ROW_WIDTH, c3v_pkg::CFG_W'(w));
        write_reg(c3v_pkg::REG_ROW_COUNT, c3v_pkg::CFG_W'(h));
        write_reg(c3v_pkg::REG_COEF_ROW0, c0);
        write_reg(c3v_pkg::REG_COEF_ROW1, c1);
        write_reg(c3v_pkg::REG_COEF_ROW2, c2);
        wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned                   n;
        int unsigned                   sent;
        logic [c3v_pkg::DIM_REG_W-1:0] w;
        logic [c3v_pkg::DIM_REG_W-1:0] h;
        bit                            restart;

        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_index               = c3v_pkg::REG_ROW_WIDTH;
        wr_data                = '0;
        pixels_bus.valid       = 1'b0;
        pixels_bus.pixel       = '0;
        pixels_bus.frame_start = 1'b0;
        steady                 = 1'b0;
        sent                   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: the start of a frame on the widest line, no window completes yet.
        for (int i = 0; i < 40; i++)
            send_pixel(pick_pixel(), i == 0);
        sent += 40;
        finish_phase();

        // Width and height above the range clamp to the maximum; the frame goes on.
        apply_config(12'hFFF, 12'hFFF, pick_coef_row(), pick_coef_row(), pick_coef_row());
        for (int i = 0; i < 20; i++)
            send_pixel(pick_pixel(), 1'b0);
        sent += 20;
        finish_phase();

        // Smallest frame, most negative coefficients and brightest pixels: lowest sum.
        apply_config(12'd3, 12'd3, 48'h8000_8000_8000, 48'h8000_8000_8000,
                     48'h8000_8000_8000);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, i == 0);
        sent += 9;
        finish_phase();

        // Sizes below three clamp upward; the frame wraps without a frame start, and the
        // largest coefficients give the highest sum.
        apply_config(12'd0, 12'd1, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                     48'h7FFF_7FFF_7FFF);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, 1'b0);
        sent += 9;
        finish_phase();

        // Geometry shrinks mid-frame: a column and a row beyond the new last ones wrap.
        apply_config(12'd4, 12'd4, pick_coef_row(), pick_coef_row(), pick_coef_row());
        for (int i = 0; i < 11; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0, i == 0);
        sent += 11;
        finish_phase();
        apply_config(12'd2, 12'd2, pick_coef_row(), pick_coef_row(), pick_coef_row());
        send_pixel(pick_pixel(), 1'b0);
        sent += 1;
        finish_phase();

        // The result side holds off while pixels keep coming, so the core fills up.
        apply_config(12'd3, 12'hFFF, pick_coef_row(), pick_coef_row(), pick_coef_row());
        steady       = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 80; i++)
            send_pixel(pick_pixel(), i == 0);
        sent += 80;
        finish_phase();

        // Random phases. A phase may skip the frame start only when the line does not
        // grow, so no line store entry is read before it was written.
        while (sent < TOTAL_ITEMS)
        begin
            w       = pick_dim(1'b1);
            h       = pick_dim(1'b0);
            restart = (sums.clamp_dim(w, LINE_LEN) > sums.active_width()) ||
                      ($urandom_range(0, 2) != 0);
            apply_config(w, h, pick_coef_row(), pick_coef_row(), pick_coef_row());
            steady = ($urandom_range(0, 3) == 0);
            n      = $urandom_range(20, 90);
            for (int i = 0; i < n; i++)
                send_pixel(pick_pixel(), (i == 0) ? restart : ($urandom_range(0, 59) == 0));
            sent += n;
            finish_phase();
        end

        if (sums.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
